@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the property checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, quiet while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication shorthand with the same clocking
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/plc_pkg.sv @@
package plc_pkg;

    // default sizing
    localparam int MAX_CLUSTERS_DEF = 32;
    localparam int MAX_POINTS_DEF   = 255;
    localparam int COORD_BITS_DEF   = 16;

    // fixed field widths
    localparam int DIST_W = 36;
    localparam int CNT_W  = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 1'd1;

    // register reset values
    localparam logic [DIST_W-1:0] MAX_DIST_RESET  = 36'd262144;
    localparam logic [CNT_W-1:0]  MIN_COUNT_RESET = 8'd3;

    // output tuser bit positions
    localparam int USER_FOUND    = 0;
    localparam int USER_OVERFLOW = 1;
    localparam int USER_W        = 2;

endpackage

@@ hw/rtl/plc_ram.sv @@
module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/point_leader_clustering.sv @@
// channel   | dir | payload
// s_axis    | in  | tdata: point_x, point_y; tlast: last_point
// m_axis    | out | tdata: center_x, center_y, best_count; tuser: found, overflow
// cfg write | in  | index 0 max_dist_squared, index 1 min_cluster_count
//
// a point is compared with each open cluster in turn, and each merge
// runs the new mean through the shared multiplier and the bit-serial divider
// a last point then searches the open clusters for the best one and reports it
// s_axis_tready is high only while idle; a held result stalls the report step
// reset is synchronous, active low, and empties the cluster store at once
module point_leader_clustering
    import plc_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // point_x, point_y
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tlast,
    output logic                   s_axis_tready,
    // center_x, center_y, best_count
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // found, overflow
    output logic [USER_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIST_W-1:0]      i_cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int MW   = CB + 1;
    localparam int PW   = 2 * MW;
    localparam int SW   = CB + 10;
    localparam int DW   = CB + 9;
    localparam int DCW  = $clog2(DW);
    localparam int CMPW = (PW > DIST_W) ? PW : DIST_W;
    localparam int EW   = 2 * CB + CNT_W;
    localparam int IW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int OW   = $clog2(MAX_CLUSTERS + 1);
    localparam int CAP_I = (MAX_POINTS < 255) ? MAX_POINTS : 255;
    localparam logic [CNT_W-1:0] CAP = CAP_I[CNT_W-1:0];
    localparam logic [OW-1:0] MAX_OPEN = MAX_CLUSTERS[OW-1:0];

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;
    localparam logic [3:0] S_NEW  = 4'd10;
    localparam logic [3:0] S_SRD  = 4'd11;
    localparam logic [3:0] S_SCMP = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]          r_state;
    logic [DIST_W-1:0]   r_max_dist;
    logic [CNT_W-1:0]    r_min_count;
    logic [CB-1:0]       r_px, r_py;
    logic                r_last;
    logic                r_merged;
    logic                r_dropped;
    logic [OW-1:0]       r_open;
    logic [OW-1:0]       r_idx;
    logic [CB-1:0]       r_cx, r_cy;
    logic [CNT_W-1:0]    r_cn;
    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]       r_dsq;
    logic                r_sel;
    logic                r_neg;
    logic [DW-1:0]       r_num;
    logic [8:0]          r_rem;
    logic [DCW-1:0]      r_dcnt;
    logic [CB-1:0]       r_bx, r_by;
    logic [CNT_W-1:0]    r_bcnt;
    logic                r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [USER_W-1:0]   r_m_user;

    logic [EW-1:0]       ram_q, ram_wdata;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [CB-1:0]       q_x, q_y;
    logic [CNT_W-1:0]    q_cnt;

    assign q_x   = ram_q[CB-1:0];
    assign q_y   = ram_q[2*CB-1:CB];
    assign q_cnt = ram_q[EW-1:2*CB];

    // cluster store
    plc_ram #(.WIDTH(EW), .DEPTH(MAX_CLUSTERS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_q)
    );

    // shared signed multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [MW-1:0] dx, dy;

    assign dx = $signed({r_px[CB-1], r_px}) - $signed({q_x[CB-1], q_x});
    assign dy = $signed({r_py[CB-1], r_py}) - $signed({r_cy[CB-1], r_cy});

    always_comb begin
        mul_a = dx;
        mul_b = dx;
        case (r_state)
            S_SQY: begin
                mul_a = dy;
                mul_b = dy;
            end
            S_MUL: begin
                mul_a = r_sel ? $signed({r_cy[CB-1], r_cy}) : $signed({r_cx[CB-1], r_cx});
                mul_b = $signed({{(MW-CNT_W){1'b0}}, r_cn});
            end
            default: begin
                mul_a = dx;
                mul_b = dx;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // distance test
    logic [PW-1:0]   dsq_sum;
    logic            dist_hit;
    assign dsq_sum  = r_dsq + $unsigned(r_prod);
    assign dist_hit = CMPW'(dsq_sum) < CMPW'(r_max_dist);

    // running mean numerator and rounding offset
    logic signed [SW-1:0] sum_s;
    logic [SW-1:0]        sum_mag;
    logic [8:0]           div_d;
    logic [CB-1:0]        p_sel;
    assign p_sel   = r_sel ? r_py : r_px;
    assign sum_s   = $signed(r_prod[SW-1:0]) + $signed({{(SW-CB){p_sel[CB-1]}}, p_sel});
    assign sum_mag = sum_s[SW-1] ? SW'(-sum_s) : $unsigned(sum_s);
    assign div_d   = {1'b0, r_cn} + 9'd1;

    // restoring divider step
    logic [9:0] div_t;
    logic       div_ge;
    assign div_t  = {r_rem, r_num[DW-1]};
    assign div_ge = div_t >= {1'b0, div_d};

    // rounded quotient back to a coordinate
    logic [CB-1:0] mean_q;
    assign mean_q = r_neg ? CB'(-r_num[CB-1:0]) : r_num[CB-1:0];

    logic [OW-1:0]    idx_inc;
    logic [CNT_W-1:0] cnt_inc;
    assign idx_inc = r_idx + OW'(1);
    assign cnt_inc = (r_cn < CAP) ? r_cn + CNT_W'(1) : r_cn;

    // store write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = {cnt_inc, r_cy, r_cx};
        case (r_state)
            S_WR: begin
                ram_we = 1'b1;
            end
            S_NEW: begin
                ram_we    = !r_merged && (r_open < MAX_OPEN);
                ram_waddr = r_open[IW-1:0];
                ram_wdata = {CNT_W'(1), r_py, r_px};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist  <= MAX_DIST_RESET;
            r_min_count <= MIN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                REG_MIN_COUNT: r_min_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_open    <= '0;
            r_dropped <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // the report step reloads the result itself
            if (r_m_valid && m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_px     <= s_axis_tdata[CB-1:0];
                        r_py     <= s_axis_tdata[2*CB-1:CB];
                        r_last   <= s_axis_tlast;
                        r_merged <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= (r_open == '0) ? S_NEW : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_cx    <= q_x;
                    r_cy    <= q_y;
                    r_cn    <= q_cnt;
                    r_prod  <= mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_dsq   <= $unsigned(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (dist_hit) begin
                        r_sel   <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= (idx_inc == r_open) ? S_NEW : S_RD;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_neg   <= sum_s[SW-1];
                    r_num   <= sum_mag[DW-1:0] + DW'(div_d[8:1]);
                    r_rem   <= '0;
                    r_dcnt  <= DCW'(DW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= div_ge ? 9'(div_t - {1'b0, div_d}) : div_t[8:0];
                    r_num  <= {r_num[DW-2:0], div_ge};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_sel) begin
                        r_cy    <= mean_q;
                        r_state <= S_WR;
                    end else begin
                        r_cx    <= mean_q;
                        r_sel   <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_WR: begin
                    r_merged <= 1'b1;
                    r_idx    <= idx_inc;
                    r_state  <= (idx_inc == r_open) ? S_NEW : S_RD;
                end
                S_NEW: begin
                    if (!r_merged) begin
                        if (r_open < MAX_OPEN) begin
                            r_open <= r_open + OW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                    r_idx   <= '0;
                    r_state <= r_last ? S_SRD : S_IDLE;
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    // first cluster with the highest count wins
                    if (r_idx == '0 || q_cnt > r_bcnt) begin
                        r_bx   <= q_x;
                        r_by   <= q_y;
                        r_bcnt <= q_cnt;
                    end
                    r_idx   <= idx_inc;
                    r_state <= (idx_inc == r_open) ? S_OUT : S_SRD;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_TDATA_W'({r_bcnt, r_by, r_bx});
                        r_m_user[USER_FOUND]    <= r_bcnt >= r_min_count;
                        r_m_user[USER_OVERFLOW] <= r_dropped;
                        r_open    <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/plc_checker.sv @@
`include "assert_macros.svh"

module plc_props
    import plc_pkg::*;
#(
    parameter int IN_W  = 32,
    parameter int OUT_W = 40
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tlast,
    input logic              s_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [USER_W-1:0] m_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready
);

    logic [CNT_W-1:0] out_count;
    assign out_count = m_axis_tdata[OUT_W-1 -: CNT_W] | m_axis_tdata[IN_W +: CNT_W];

    // a stalled result holds its payload
    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // one point at a time: busy right after a request is taken
    `ASSERT_CLK(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after a point")

    // a point that is not last never raises a result next cycle
    `ASSERT_CLK(a_no_early_result, s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid), "result after a non-last point")

    // a reported cluster always holds at least one point
    `ASSERT_IMPL(a_count_nonzero, m_axis_tvalid, out_count != '0, "best count of zero")

endmodule

bind point_leader_clustering plc_props #(
    .IN_W  (IN_TDATA_W),
    .OUT_W (OUT_TDATA_W)
) u_plc_props (.*);

@@ verif/plc_checker.sv @@
`timescale 1ns / 100ps

module plc_checker
    import plc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // point_x, point_y
    input  logic [31:0]       s_axis_tdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tlast,
    input  logic              s_axis_tready,
    // center_x, center_y, best_count
    input  logic [39:0]       m_axis_tdata,
    // found, overflow
    input  logic [USER_W-1:0] m_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int STORE_DEPTH = MAX_CLUSTERS_DEF;
    localparam int COUNT_CAP   = (MAX_POINTS_DEF < 255) ? MAX_POINTS_DEF : 255;

    typedef struct {
        logic               found;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [7:0]         best_count;
        logic               overflow;
    } set_report_t;

    // own copy of the cluster store and the registers
    longint      ctr_x [STORE_DEPTH];
    longint      ctr_y [STORE_DEPTH];
    int          members [STORE_DEPTH];
    int          open_clusters;
    bit          dropped;
    logic [DIST_W-1:0] dist_limit;
    logic [CNT_W-1:0]  min_members;
    set_report_t report_q [$];
    int          fails;

    initial begin
        fails = 0;
    end

    // running mean, rounded to nearest with ties away from zero
    function automatic longint running_mean(longint c, int n, longint p);
        longint s;
        longint d;
        longint mag;
        longint q;
        s = c * n + p;
        d = n + 1;
        mag = (s < 0) ? -s : s;
        q = (mag + d / 2) / d;
        return (s < 0) ? -q : q;
    endfunction

    // merge a point into the store, and report the set on its last point
    task automatic absorb_point(logic signed [15:0] px_in, logic signed [15:0] py_in,
                                logic is_last);
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint unsigned dsq;
        bit merged;
        int best;
        set_report_t rep;
        px = px_in;
        py = py_in;
        merged = 0;
        for (int i = 0; i < open_clusters; i++) begin
            dx = px - ctr_x[i];
            dy = py - ctr_y[i];
            dsq = longint'(dx * dx) + longint'(dy * dy);
            if (dsq < {28'd0, dist_limit}) begin
                ctr_x[i] = running_mean(ctr_x[i], members[i], px);
                ctr_y[i] = running_mean(ctr_y[i], members[i], py);
                if (members[i] < COUNT_CAP)
                    members[i] = members[i] + 1;
                merged = 1;
            end
        end
        if (!merged) begin
            if (open_clusters < STORE_DEPTH) begin
                ctr_x[open_clusters] = px;
                ctr_y[open_clusters] = py;
                members[open_clusters] = 1;
                open_clusters++;
            end else begin
                dropped = 1;
            end
        end
        if (is_last) begin
            best = 0;
            for (int i = 1; i < open_clusters; i++)
                if (members[i] > members[best])
                    best = i;
            rep.found      = (members[best] >= min_members);
            rep.center_x   = ctr_x[best][15:0];
            rep.center_y   = ctr_y[best][15:0];
            rep.best_count = members[best][7:0];
            rep.overflow   = dropped;
            report_q.push_back(rep);
            open_clusters = 0;
            dropped = 0;
        end
    endtask

    // compare one delivered report with the oldest prediction
    task automatic check_report();
        set_report_t exp_rep;
        logic signed [15:0] got_x;
        logic signed [15:0] got_y;
        got_x = m_axis_tdata[15:0];
        got_y = m_axis_tdata[31:16];
        if (report_q.size() == 0) begin
            $error("report with none predicted");
            fails++;
        end else begin
            exp_rep = report_q.pop_front();
            if (m_axis_tuser[USER_FOUND] !== exp_rep.found) begin
                $error("found expected %0d got %0d", exp_rep.found, m_axis_tuser[USER_FOUND]);
                fails++;
            end
            if (got_x !== exp_rep.center_x) begin
                $error("center_x expected %0d got %0d", exp_rep.center_x, got_x);
                fails++;
            end
            if (got_y !== exp_rep.center_y) begin
                $error("center_y expected %0d got %0d", exp_rep.center_y, got_y);
                fails++;
            end
            if (m_axis_tdata[39:32] !== exp_rep.best_count) begin
                $error("best_count expected %0d got %0d", exp_rep.best_count,
                       m_axis_tdata[39:32]);
                fails++;
            end
            if (m_axis_tuser[USER_OVERFLOW] !== exp_rep.overflow) begin
                $error("overflow expected %0d got %0d", exp_rep.overflow,
                       m_axis_tuser[USER_OVERFLOW]);
                fails++;
            end
        end
    endtask

    // watch register writes and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_clusters = 0;
            dropped = 0;
            dist_limit = MAX_DIST_RESET;
            min_members = MIN_COUNT_RESET;
            report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAX_DIST:  dist_limit = i_cfg_data;
                    REG_MIN_COUNT: min_members = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (s_axis_tvalid && s_axis_tready)
                absorb_point(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        end
        o_pending <= report_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/tb_point_leader_clustering.sv @@
`timescale 1ns / 100ps

module tb_point_leader_clustering;
    import plc_pkg::*;

    localparam int  CYCLE_LIMIT = 12000000;
    localparam int  HOLD_LEN    = 3000;
    localparam logic [DIST_W-1:0] DIST_FULL = {DIST_W{1'b1}};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [31:0]       s_axis_tdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tlast = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIST_W-1:0] i_cfg_data = '0;

    int  fail_count;
    int  pending;
    int  cyc = 0;
    int  points_sent = 0;
    int  sets_sent = 0;
    bit  quiet = 0;
    bit  hold_go = 0;
    bit  hold_done = 0;
    int  hold_cyc = 0;

    point_leader_clustering u_top (.*);

    plc_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tdata, .s_axis_tvalid, .s_axis_tlast, .s_axis_tready,
        .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cycle count and run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cyc <= hold_cyc + 1;
            if (hold_cyc == HOLD_LEN - 1)
                hold_done <= 1'b1;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    // offer one point request and wait for it to be taken
    task automatic send_point(logic signed [15:0] px, logic signed [15:0] py, logic is_last);
        if (!quiet && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 50)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        points_sent++;
        if (is_last)
            sets_sent++;
    endtask

    // stop offering, then let every report arrive and the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !s_axis_tready)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [DIST_W-1:0] dist_val, logic [CNT_W-1:0] min_cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_DIST;
        i_cfg_data  <= dist_val;
        @(posedge i_clk);
        i_cfg_index <= REG_MIN_COUNT;
        i_cfg_data  <= {{(DIST_W-CNT_W){1'b0}}, min_cnt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // sets of points scattered around a few seeds, with some stray points
    task automatic random_sets(int target);
        int start;
        int len;
        int seeds;
        int spread;
        int sx [4];
        int sy [4];
        int k;
        logic signed [15:0] px;
        logic signed [15:0] py;
        start = points_sent;
        while (points_sent - start < target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(31, 45) : $urandom_range(1, 25);
            seeds = $urandom_range(1, 4);
            case ($urandom_range(3))
                0: spread = 16;
                1: spread = 300;
                2: spread = 1500;
                default: spread = 9000;
            endcase
            for (int s = 0; s < 4; s++) begin
                sx[s] = $urandom_range(65535) - 32768;
                sy[s] = $urandom_range(65535) - 32768;
            end
            for (int j = 0; j < len; j++) begin
                k = $urandom_range(seeds - 1);
                if ($urandom_range(9) == 0) begin
                    px = 16'($urandom());
                    py = 16'($urandom());
                end else begin
                    px = clamp16(sx[k] + $urandom_range(2 * spread) - spread);
                    py = clamp16(sy[k] + $urandom_range(2 * spread) - spread);
                end
                send_point(px, py, j == len - 1);
            end
        end
    endtask

    logic [DIST_W-1:0] dist_pick;
    logic [CNT_W-1:0]  min_pick;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets at reset settings: extremes, rounding ties both signs
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd1, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(-16'sd1, -16'sd1, 1'b1);
        send_point(16'sd100, -16'sd100, 1'b0);
        send_point(16'sd400, -16'sd100, 1'b0);
        send_point(16'sd250, 16'sd200, 1'b1);
        send_point(16'sd5, 16'sd5, 1'b1);
        drain();

        // full-scale threshold and zero minimum: everything merges, always found
        write_regs(DIST_FULL, 8'd0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b1);
        drain();

        // zero threshold: nothing merges, store fills and drops points
        write_regs('0, 8'd255);
        for (int j = 0; j < 40; j++)
            send_point(16'($urandom()), 16'($urandom()), j == 39);
        drain();

        // one long set on a single spot so the count saturates
        write_regs(36'd1048576, 8'd255);
        for (int j = 0; j < 262; j++)
            send_point(clamp16(100 + $urandom_range(16) - 8),
                       clamp16(-100 + $urandom_range(16) - 8), j == 261);
        drain();

        // random phases over a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 5)
                0: dist_pick = 36'd262144;
                1: dist_pick = 36'd1;
                2: dist_pick = DIST_FULL;
                3: dist_pick = DIST_W'({$urandom(), $urandom()});
                default: dist_pick = 36'd1 << $urandom_range(10, 26);
            endcase
            case ($urandom_range(2))
                0: min_pick = 8'd1;
                1: min_pick = 8'd255;
                default: min_pick = CNT_W'($urandom_range(1, 6));
            endcase
            write_regs(dist_pick, min_pick);
            quiet <= (ph == 3);
            if (ph == 5)
                hold_go <= 1'b1;
            random_sets(60);
            drain();
        end
        quiet <= 1'b0;
        repeat (100) @(posedge i_clk);

        $display("covered %0d points in %0d sets: merges, store overflow, count saturation,",
                 points_sent, sets_sent);
        $display("thresholds from zero to full scale, minimum counts from zero to 255");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
